/* hdl/assert_macros.svh */
// Assertion helpers used by the top-level decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be seen out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

/* hdl/lbsd_pkg.sv */
package lbsd_pkg;

    localparam int WINDOW_BITS   = 13;
    localparam int LENGTH_BITS   = 4;
    localparam int MIN_MATCH     = 3;
    localparam int LIT_BITS      = 8;
    localparam int BITS_PER_BYTE = 8;
    localparam int WIN_DEPTH     = 1 << WINDOW_BITS;
    localparam int ACC_W         = WINDOW_BITS + LENGTH_BITS;
    localparam int HELD_W        = $clog2(ACC_W + 1);
    localparam int REM_W         = $clog2((1 << LENGTH_BITS) + MIN_MATCH);
    localparam int FILL_W        = WINDOW_BITS + 1;
    localparam int CNT_W         = $clog2(BITS_PER_BYTE);
    localparam int COUNT_W       = 32;
    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(BITS_PER_BYTE - 1);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_POS,
        PH_LEN
    } t_phase;

    typedef enum logic [1:0] {
        BK_NONE,
        BK_LIT,
        BK_ENDM,
        BK_COPY
    } t_bit_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_BIT,
        S_RD,
        S_WR,
        S_STAT
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic take_bit;
        logic rd_issue;
        logic emit_copy;
        logic push_status;
    } t_cmd;

    typedef struct packed {
        logic      finished;
        t_bit_kind kind;
        logic      slot_free;
        logic      copy_last;
        logic      fin_emit;
    } t_stat;

endpackage

/* hdl/lbsd_ram.sv */
module lbsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lbsd_ctrl.sv */
module lbsd_ctrl
    import lbsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_emitted, n_emitted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_emitted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_emitted <= n_emitted;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_emitted = r_emitted;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state   = S_BIT;
                n_cnt     = '0;
                n_emitted = 1'b0;
            end
            S_BIT: begin
                if (i_stat.finished) begin
                    n_state = r_emitted ? S_IDLE : S_STAT;
                end else begin
                    case (i_stat.kind)
                        BK_LIT: begin
                            if (i_stat.slot_free) begin
                                n_emitted = 1'b1;
                                if (r_cnt == BIT_LAST) begin
                                    n_state = S_IDLE;
                                end else begin
                                    n_cnt = r_cnt + 1'b1;
                                end
                            end
                        end
                        BK_COPY: begin
                            n_state = S_RD;
                        end
                        default: begin
                            if (r_cnt == BIT_LAST) begin
                                n_state = r_emitted ? S_IDLE : S_STAT;
                            end else begin
                                n_cnt = r_cnt + 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (i_stat.slot_free) begin
                    n_emitted = 1'b1;
                    if (i_stat.copy_last || i_stat.fin_emit) begin
                        if (r_cnt == BIT_LAST) begin
                            n_state = S_IDLE;
                        end else begin
                            n_cnt   = r_cnt + 1'b1;
                            n_state = S_BIT;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_STAT: begin
                if (i_stat.slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
            end
            S_BIT: begin
                o_cmd.take_bit = !i_stat.finished &&
                                 (i_stat.kind != BK_LIT || i_stat.slot_free);
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            S_WR: begin
                o_cmd.emit_copy = i_stat.slot_free;
            end
            S_STAT: begin
                o_cmd.push_status = i_stat.slot_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/lbsd_dpath.sv */
module lbsd_dpath
    import lbsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [7:0]         i_in_byte,
    input  logic               i_start_req,
    input  logic               i_cfg_valid,
    input  logic [COUNT_W-1:0] i_cfg_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_out_last,
    output logic               o_out_byte_valid,
    output logic               o_out_done
);

    logic [7:0]             r_byte;
    logic                   r_start;
    t_phase                 r_phase, n_phase;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [HELD_W-1:0]      r_held, n_held;
    logic [WINDOW_BITS-1:0] r_wptr;
    logic [FILL_W-1:0]      r_fill;
    logic [COUNT_W-1:0]     r_bytes_out;
    logic                   r_finished;
    logic [COUNT_W-1:0]     r_out_length;
    logic [WINDOW_BITS-1:0] r_cpos;
    logic [REM_W-1:0]       r_rem;
    logic                   r_rd_ok;
    logic                   r_ovalid;
    logic [7:0]             r_odata;
    logic                   r_olast;
    logic                   r_obvalid;
    logic                   r_odone;

    logic                   bit_in;
    logic [ACC_W-1:0]       acc_sh;
    logic [HELD_W-1:0]      held_inc;
    t_bit_kind              kind;
    logic                   slot_free;
    logic                   emit;
    logic                   push;
    logic [7:0]             emit_byte;
    logic [7:0]             ram_q;
    logic                   fin_emit;
    logic                   copy_last;
    logic                   rd_ok;
    logic [COUNT_W-1:0]     prep_count;
    logic                   prep_fin;

    assign bit_in   = r_byte[7];
    assign acc_sh   = {r_acc[ACC_W-2:0], bit_in};
    assign held_inc = r_held + 1'b1;

    always_comb begin
        kind    = BK_NONE;
        n_phase = r_phase;
        n_acc   = acc_sh;
        n_held  = held_inc;
        case (r_phase)
            PH_FLAG: begin
                n_phase = bit_in ? PH_LIT : PH_POS;
                n_acc   = '0;
                n_held  = '0;
            end
            PH_LIT: begin
                if (held_inc >= HELD_W'(LIT_BITS)) begin
                    kind    = BK_LIT;
                    n_phase = PH_FLAG;
                    n_acc   = '0;
                    n_held  = '0;
                end
            end
            PH_POS: begin
                if (held_inc >= HELD_W'(WINDOW_BITS)) begin
                    if (acc_sh[WINDOW_BITS-1:0] == '0) begin
                        kind    = BK_ENDM;
                        n_phase = PH_FLAG;
                        n_acc   = '0;
                        n_held  = '0;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                if (held_inc >= HELD_W'(ACC_W)) begin
                    kind    = BK_COPY;
                    n_phase = PH_FLAG;
                    n_acc   = '0;
                    n_held  = '0;
                end
            end
            default: begin
                n_phase = PH_FLAG;
            end
        endcase
    end

    assign slot_free = !r_ovalid || i_out_ready;
    assign fin_emit  = (r_bytes_out + 1'b1) >= r_out_length;
    assign copy_last = (r_rem == REM_W'(1));
    assign emit      = (i_cmd.take_bit && kind == BK_LIT) || i_cmd.emit_copy;
    assign push      = emit || i_cmd.push_status;
    assign emit_byte = i_cmd.emit_copy ? (r_rd_ok ? ram_q : 8'd0) : acc_sh[7:0];
    assign rd_ok     = r_fill[WINDOW_BITS] || ({1'b0, r_cpos} < r_fill);

    assign prep_count = r_start ? '0 : r_bytes_out;
    assign prep_fin   = (!r_start && r_finished) || (prep_count >= r_out_length);

    assign o_stat.finished  = r_finished;
    assign o_stat.kind      = kind;
    assign o_stat.slot_free = slot_free;
    assign o_stat.copy_last = copy_last;
    assign o_stat.fin_emit  = fin_emit;

    lbsd_ram #(
        .WIDTH(8),
        .DEPTH(WIN_DEPTH)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (emit),
        .i_waddr(r_wptr),
        .i_wdata(emit_byte),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(r_cpos),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG;
            r_acc        <= '0;
            r_held       <= '0;
            r_wptr       <= '0;
            r_fill       <= '0;
            r_bytes_out  <= '0;
            r_finished   <= 1'b0;
            r_out_length <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_out_length <= i_cfg_data;
            end
            if (i_cmd.prep) begin
                if (r_start) begin
                    r_phase     <= PH_FLAG;
                    r_acc       <= '0;
                    r_held      <= '0;
                    r_wptr      <= '0;
                    r_fill      <= '0;
                    r_bytes_out <= '0;
                end
                r_finished <= prep_fin;
            end
            if (i_cmd.take_bit) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_held  <= n_held;
                if (kind == BK_ENDM) begin
                    r_finished <= 1'b1;
                end
            end
            if (emit) begin
                r_wptr      <= r_wptr + 1'b1;
                r_bytes_out <= r_bytes_out + 1'b1;
                r_finished  <= fin_emit;
                if (!r_fill[WINDOW_BITS]) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte  <= i_in_byte;
            r_start <= i_start_req;
        end else if (i_cmd.take_bit) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
        if (i_cmd.take_bit && kind == BK_COPY) begin
            r_cpos <= acc_sh[ACC_W-1:LENGTH_BITS] - 1'b1;
            r_rem  <= REM_W'(acc_sh[LENGTH_BITS-1:0]) + REM_W'(MIN_MATCH);
        end else begin
            if (i_cmd.rd_issue) begin
                r_cpos <= r_cpos + 1'b1;
            end
            if (i_cmd.emit_copy) begin
                r_rem <= r_rem - 1'b1;
            end
        end
        if (i_cmd.rd_issue) begin
            r_rd_ok <= rd_ok;
        end
        if (i_cmd.push_status) begin
            r_odata   <= 8'd0;
            r_obvalid <= 1'b0;
            r_olast   <= 1'b1;
            r_odone   <= r_finished;
        end else if (emit) begin
            r_odata   <= emit_byte;
            r_obvalid <= 1'b1;
            r_olast   <= i_cmd.emit_copy ? (copy_last || fin_emit) : 1'b1;
            r_odone   <= fin_emit;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_byte       = r_odata;
    assign o_out_last       = r_olast;
    assign o_out_byte_valid = r_obvalid;
    assign o_out_done       = r_odone;

endmodule

/* hdl/lzss_bit_stream_decoder.sv */
// LZSS decoder with an 8 KiB window. Each compressed byte is read most significant bit
// first: flag 1 plus an 8-bit literal, or flag 0 plus a 13-bit absolute window position
// and a 4-bit length (length+3 bytes copied starting at position-1); position 0 ends the
// stream. tuser on the input marks the first byte of a stream and clears window, parser
// and counters. Every input byte gives one or more output items; tlast marks the last one,
// and a byte that yields no data gives a single status item with byte_valid low. The
// stream finishes at the end marker or once out_length bytes have been produced; further
// bytes then give status items until the next start. A byte is loaded (IDLE, then PREP),
// then parsed one bit per cycle, pausing while a literal waits for the output; each byte
// copied from the window takes a read (RD) and a write-back (WR), a status item is pushed
// in STAT, and every push waits while the output side stalls. Once the stream is finished,
// the bits left in the byte are skipped rather than parsed. The pace is set by the parser
// and the window RAM's registered read, which each copied byte waits on before write-back.
// The window needs no clearing pass: a fill count marks entries written since the start.
// Write out_length only while no byte is being processed.
`include "assert_macros.svh"

module lzss_bit_stream_decoder
    import lbsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,  // [7:0] in_byte
    input  logic               i_s_axis_tuser,  // [0] start_req
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,  // [7:0] out_byte
    output logic               o_m_axis_tlast,
    output logic [1:0]         o_m_axis_tuser,  // [0] byte_valid, [1] done_res
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COUNT_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lbsd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    lbsd_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_byte       (i_s_axis_tdata),
        .i_start_req     (i_s_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_out_byte      (o_m_axis_tdata),
        .o_out_last      (o_m_axis_tlast),
        .o_out_byte_valid(o_m_axis_tuser[0]),
        .o_out_done      (o_m_axis_tuser[1])
    );

    `ASSERT_ALWAYS(a_cmd_onehot, i_clk, i_rst_n, $onehot0(cmd))
    `ASSERT_NEVER(a_push_into_full, i_clk, i_rst_n,
        (cmd.emit_copy || cmd.push_status) && !stat.slot_free)
    `ASSERT_ALWAYS(a_one_byte_at_once, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
    `ASSERT_ALWAYS(a_status_item, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 8'd0 && o_m_axis_tlast)

endmodule
